>>> rtl/dns_query_encoder_macros.svh
// assertion macros for the dns query encoder
// expects clk and arst_n in the including module
`ifndef DNS_QUERY_ENCODER_MACROS_SVH
`define DNS_QUERY_ENCODER_MACROS_SVH

// same-cycle implication, disabled during reset
`define DQE_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define DQE_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/dqe_pkg.sv
// shared constants and byte tables for the dns query encoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dqe_pkg;

	localparam int LABEL_MAX_DEF = 32;

	localparam logic [7:0] CHAR_DOT    = 8'h2E;
	localparam logic [7:0] CHAR_UP_A   = 8'h41;
	localparam logic [7:0] CHAR_UP_Z   = 8'h5A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	localparam logic [7:0] FLAGS_RD    = 8'h01;
	localparam logic [7:0] COUNT_ONE   = 8'h01;
	localparam logic [7:0] TYPE_A      = 8'h01;
	localparam logic [7:0] CLASS_IN    = 8'h01;

	localparam logic [3:0] HDR_LAST    = 4'd11;
	localparam logic [3:0] FOOT_LAST   = 4'd4;

	// header: id hi, id lo, flags 0x0100, qdcount 1, an/ns/ar counts 0
	function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input logic [15:0] id);
		logic [7:0] b;
		case (idx)
			4'd0: b = id[15:8];
			4'd1: b = id[7:0];
			4'd2: b = FLAGS_RD;
			4'd5: b = COUNT_ONE;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// name terminator, qtype a, qclass in
	function automatic logic [7:0] foot_byte(input logic [3:0] idx);
		logic [7:0] b;
		case (idx)
			4'd2: b = TYPE_A;
			4'd4: b = CLASS_IN;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

>>> rtl/dqe_label_buf.sv
// label character buffer: one write port, one registered read port
// depends on dqe_pkg for the default depth
`timescale 1ns / 1ps
`default_nettype none

module dqe_label_buf #(
	parameter int DEPTH = dqe_pkg::LABEL_MAX_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [7:0]    wr_data,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

>>> rtl/dns_query_encoder.sv
// dns query encoder top level: character stream in, query message bytes out
// depends on dqe_pkg, dqe_label_buf and dns_query_encoder_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "dns_query_encoder_macros.svh"

// Takes a domain name one character per input transaction (query id on the
// first character, tlast on the final one) and sends a type A, class IN
// query message one byte per output transaction. A character is accepted
// only in the idle state and causes these bytes: 12 header bytes on the
// first character, the length byte and characters of a label when a dot or
// the last character closes it, and 5 trailing bytes at the end; the next
// character is accepted once they are emitted. The single output byte
// register holds each byte, and output back-pressure stalls the encoder.
// Label characters sit in a LABEL_MAX-entry buffer with a registered read,
// streamed out at one byte per cycle while the output is not stalled. tuser
// on the output flags that a label of the current message was cut at
// LABEL_MAX characters; it is final on the byte marked by tlast.

module dns_query_encoder #(
	parameter int LABEL_MAX = dqe_pkg::LABEL_MAX_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // name_char [7:0], query_id [23:8]
	input  wire logic        s_axis_tlast,  // last_char
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [7:0]  m_axis_tdata,  // out_byte [7:0]
	output logic             m_axis_tlast,  // end_of_message
	output logic             m_axis_tuser   // label_overflow
);

	import dqe_pkg::*;

	localparam int AW = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;
	localparam int LW = $clog2(LABEL_MAX + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_HDR  = 3'd1;
	localparam logic [2:0] ST_PROC = 3'd2;
	localparam logic [2:0] ST_FLEN = 3'd3;
	localparam logic [2:0] ST_FCHR = 3'd4;
	localparam logic [2:0] ST_FOOT = 3'd5;

	logic [2:0]    state_q, state_d;
	logic [3:0]    cnt_q, cnt_d;
	logic [LW-1:0] len_q, len_d;
	logic [AW-1:0] ptr_q, ptr_d;
	logic          in_name_q, in_name_d;
	logic          ovf_q, ovf_d;

	logic [7:0]    char_q;
	logic [15:0]   id_q;
	logic          last_q;

	logic          accept;
	logic          emit_ok;
	logic          emit;
	logic [7:0]    emit_byte;
	logic          emit_end;
	logic [7:0]    char_lc;
	logic [LW-1:0] ptr_nx;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;

	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          out_end_q;
	logic          out_ovf_q;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign emit_ok       = !out_valid_q || m_axis_tready;

	assign char_lc = ((char_q >= CHAR_UP_A) && (char_q <= CHAR_UP_Z)) ?
		(char_q + CASE_OFFSET) : char_q;
	assign ptr_nx  = LW'(ptr_q) + LW'(1);
	assign wr_addr = len_q[AW-1:0];

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		len_d     = len_q;
		ptr_d     = ptr_q;
		in_name_d = in_name_q;
		ovf_d     = ovf_q;
		emit      = 1'b0;
		emit_byte = 8'h00;
		emit_end  = 1'b0;
		wr_en     = 1'b0;
		rd_addr   = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					in_name_d = 1'b1;
					if (!in_name_q) begin
						ovf_d   = 1'b0;
						len_d   = '0;
						cnt_d   = '0;
						state_d = ST_HDR;
					end else begin
						state_d = ST_PROC;
					end
				end
			end
			ST_HDR: begin
				emit_byte = hdr_byte(cnt_q, id_q);
				if (emit_ok) begin
					emit = 1'b1;
					if (cnt_q == HDR_LAST) begin
						cnt_d   = '0;
						state_d = ST_PROC;
					end else begin
						cnt_d = cnt_q + 4'd1;
					end
				end
			end
			ST_PROC: begin
				ptr_d = '0;
				cnt_d = '0;
				if (char_q == CHAR_DOT) begin
					if (len_q != '0) begin
						state_d = ST_FLEN;
					end else if (last_q) begin
						state_d = ST_FOOT;
					end else begin
						state_d = ST_IDLE;
					end
				end else begin
					if (len_q < LW'(LABEL_MAX)) begin
						wr_en = 1'b1;
						len_d = len_q + LW'(1);
					end else begin
						ovf_d = 1'b1;
					end
					state_d = last_q ? ST_FLEN : ST_IDLE;
				end
			end
			ST_FLEN: begin
				emit_byte = 8'(len_q);
				if (emit_ok) begin
					emit    = 1'b1;
					state_d = ST_FCHR;
				end
			end
			ST_FCHR: begin
				emit_byte = rd_data;
				rd_addr   = ptr_q;
				if (emit_ok) begin
					emit = 1'b1;
					if (ptr_nx == len_q) begin
						len_d   = '0;
						ptr_d   = '0;
						cnt_d   = '0;
						rd_addr = '0;
						state_d = last_q ? ST_FOOT : ST_IDLE;
					end else begin
						ptr_d   = ptr_nx[AW-1:0];
						rd_addr = ptr_nx[AW-1:0];
					end
				end
			end
			ST_FOOT: begin
				emit_byte = foot_byte(cnt_q);
				emit_end  = (cnt_q == FOOT_LAST);
				if (emit_ok) begin
					emit = 1'b1;
					if (emit_end) begin
						in_name_d = 1'b0;
						ovf_d     = 1'b0;
						len_d     = '0;
						state_d   = ST_IDLE;
					end else begin
						cnt_d = cnt_q + 4'd1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	dqe_label_buf #(
		.DEPTH(LABEL_MAX)
	) u_label_buf (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(char_lc),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			len_q       <= '0;
			ptr_q       <= '0;
			in_name_q   <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			len_q     <= len_d;
			ptr_q     <= ptr_d;
			in_name_q <= in_name_d;
			ovf_q     <= ovf_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_q <= s_axis_tdata[7:0];
			id_q   <= s_axis_tdata[23:8];
			last_q <= s_axis_tlast;
		end
		if (emit) begin
			out_byte_q <= emit_byte;
			out_end_q  <= emit_end;
			out_ovf_q  <= ovf_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tlast  = out_end_q;
	assign m_axis_tuser  = out_ovf_q;

	`DQE_ASSERT_SAME(a_label_nonempty, state_q == ST_FCHR, (len_q != '0) && (LW'(ptr_q) < len_q), "label read outside buffered length")
	`DQE_ASSERT_NEXT(a_new_message, accept && !in_name_q, (state_q == ST_HDR) && (cnt_q == '0) && !ovf_q, "new message did not start with a clean header")
	`DQE_ASSERT_NEXT(a_message_end, emit && emit_end, !in_name_q && m_axis_tvalid && m_axis_tlast && (len_q == '0), "message end did not close the name")

endmodule

`default_nettype wire

>>> sim/tb.sv
// self-checking testbench for dns_query_encoder: feeds domain names as character
// transactions and checks every query message byte against a built-in encoder model
// depends on dqe_pkg and the dns_query_encoder rtl
`timescale 1ns / 1ps

module tb;
	import dqe_pkg::*;

	localparam int LABEL_MAX   = LABEL_MAX_DEF;
	localparam int ITEM_TARGET = 330;

	typedef logic [7:0] char_q_t[$];

	typedef struct {
		logic [7:0] data;
		logic       eom;
		logic       ovf;
	} msg_byte_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;  // name_char [7:0], query_id [23:8]
	logic        s_axis_tlast;  // last_char
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;  // out_byte [7:0]
	logic        m_axis_tlast;  // end_of_message
	logic        m_axis_tuser;  // label_overflow

	// expected message bytes and encoder state
	msg_byte_t   msg_bytes_q[$];
	logic [7:0]  enc_label[LABEL_MAX];
	int          enc_label_len;
	bit          enc_in_name;
	bit          enc_overflow;

	int          mismatches;
	int          chars_sent;
	bit          tx_gaps_on;
	bit          rx_stalls_on;
	int          rx_hold_req;

	dns_query_encoder #(
		.LABEL_MAX(LABEL_MAX)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 30);
	endfunction

	function automatic void push_byte(input logic [7:0] b, input bit eom);
		msg_byte_t e;
		e.data = b;
		e.eom  = eom;
		e.ovf  = enc_overflow;
		msg_bytes_q.push_back(e);
	endfunction

	function automatic void close_label();
		if (enc_label_len == 0)
			return;
		push_byte(8'(enc_label_len), 1'b0);
		for (int i = 0; i < enc_label_len; i++)
			push_byte(enc_label[i], 1'b0);
		enc_label_len = 0;
	endfunction

	// expected bytes caused by one accepted character
	function automatic void encode_char(input logic [7:0] c, input bit last,
			input logic [15:0] id);
		logic [7:0] ch;
		ch = c;
		if (!enc_in_name) begin
			enc_in_name   = 1'b1;
			enc_overflow  = 1'b0;
			enc_label_len = 0;
			push_byte(id[15:8], 1'b0);
			push_byte(id[7:0], 1'b0);
			push_byte(FLAGS_RD, 1'b0);
			push_byte(8'h00, 1'b0);
			push_byte(8'h00, 1'b0);
			push_byte(COUNT_ONE, 1'b0);
			for (int i = 0; i < 6; i++)
				push_byte(8'h00, 1'b0);
		end
		if (ch == CHAR_DOT) begin
			close_label();
		end else begin
			if (ch >= CHAR_UP_A && ch <= CHAR_UP_Z)
				ch = ch + CASE_OFFSET;
			if (enc_label_len < LABEL_MAX) begin
				enc_label[enc_label_len] = ch;
				enc_label_len++;
			end else begin
				enc_overflow = 1'b1;
			end
		end
		if (last) begin
			close_label();
			push_byte(8'h00, 1'b0);
			push_byte(8'h00, 1'b0);
			push_byte(TYPE_A, 1'b0);
			push_byte(8'h00, 1'b0);
			push_byte(CLASS_IN, 1'b1);
			enc_in_name   = 1'b0;
			enc_overflow  = 1'b0;
			enc_label_len = 0;
		end
	endfunction

	// output transaction check
	always @(posedge clk) begin
		msg_byte_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (msg_bytes_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected byte %02h tlast %b tuser %b", $realtime,
						m_axis_tdata, m_axis_tlast, m_axis_tuser);
			end else begin
				e = msg_bytes_q.pop_front();
				if (m_axis_tdata !== e.data || m_axis_tlast !== e.eom ||
						m_axis_tuser !== e.ovf) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: expected %02h/%b/%b got %02h/%b/%b (byte/tlast/tuser)",
							$realtime, e.data, e.eom, e.ovf,
							m_axis_tdata, m_axis_tlast, m_axis_tuser);
				end
			end
		end
	end

	// receiver: random stalls plus a long hold-off on request
	initial begin : rx_side
		int hold_left;
		int stall_left;
		hold_left = 0;
		stall_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req > 0) begin
				hold_left = rx_hold_req;
				rx_hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (rx_stalls_on)
					stall_left = pick_gap();
			end
		end
	end

	task automatic send_char(input logic [7:0] c, input bit last, input logic [15:0] id);
		int gap;
		gap = tx_gaps_on ? pick_gap() : 0;
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {id, c};
		s_axis_tlast  <= last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		encode_char(c, last, id);
		chars_sent++;
	endtask

	// id goes with the first character; later ones carry random ids that must be ignored
	task automatic send_name(input char_q_t chars, input logic [15:0] id);
		for (int i = 0; i < chars.size(); i++)
			send_char(chars[i], i == chars.size() - 1,
				i == 0 ? id : 16'($urandom_range(0, 65535)));
	endtask

	task automatic wait_drained();
		while (msg_bytes_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] rand_label_char();
		int r;
		logic [7:0] c;
		r = $urandom_range(0, 9);
		if (r < 5)
			c = 8'($urandom_range(8'h61, 8'h7A));
		else if (r < 7)
			c = 8'($urandom_range(CHAR_UP_A, CHAR_UP_Z));
		else if (r < 8)
			c = 8'($urandom_range(8'h30, 8'h39));
		else if (r < 9)
			c = 8'h2D;
		else
			c = 8'($urandom_range(0, 255));
		if (c == CHAR_DOT)
			c = 8'h78;
		return c;
	endfunction

	function automatic char_q_t random_name();
		char_q_t q;
		int labels;
		int len;
		labels = $urandom_range(1, 4);
		if ($urandom_range(0, 9) == 0)
			q.push_back(CHAR_DOT);
		for (int l = 0; l < labels; l++) begin
			if ($urandom_range(0, 19) == 0)
				len = $urandom_range(LABEL_MAX - 2, LABEL_MAX + 8);
			else
				len = $urandom_range(1, 10);
			for (int i = 0; i < len; i++)
				q.push_back(rand_label_char());
			if (l != labels - 1) begin
				q.push_back(CHAR_DOT);
				if ($urandom_range(0, 9) == 0)
					q.push_back(CHAR_DOT);
			end
		end
		if ($urandom_range(0, 7) == 0)
			q.push_back(CHAR_DOT);
		return q;
	endfunction

	function automatic char_q_t noise_name();
		char_q_t q;
		int len;
		len = $urandom_range(1, 12);
		for (int i = 0; i < len; i++)
			q.push_back($urandom_range(0, 3) == 0 ? CHAR_DOT : 8'($urandom_range(0, 255)));
		return q;
	endfunction

	task automatic test_root_and_single();
		char_q_t q;
		q = '{CHAR_DOT};
		send_name(q, 16'h0000);
		q = '{CHAR_UP_A};
		send_name(q, 16'hFFFF);
	endtask

	// leading, repeated and trailing dots
	task automatic test_empty_labels();
		char_q_t q;
		q = '{CHAR_DOT, CHAR_DOT, CHAR_UP_A, 8'h62, CHAR_DOT, CHAR_DOT, 8'h7A, CHAR_DOT};
		send_name(q, 16'hA55A);
	endtask

	// bytes around the upper-case range and the byte extremes
	task automatic test_char_boundaries();
		char_q_t q;
		q = '{8'h00, 8'h40, CHAR_UP_A, CHAR_UP_Z, 8'h5B, 8'h60, 8'h7B, 8'hFF};
		send_name(q, 16'h5AA5);
	endtask

	// a full-length label, then a cut label, then a short one; the flag must clear after
	task automatic test_label_overflow();
		char_q_t q;
		for (int i = 0; i < LABEL_MAX; i++)
			q.push_back(rand_label_char());
		q.push_back(CHAR_DOT);
		for (int i = 0; i < LABEL_MAX + 7; i++)
			q.push_back(rand_label_char());
		q.push_back(CHAR_DOT);
		q.push_back(8'h61);
		q.push_back(CHAR_UP_Z);
		send_name(q, 16'($urandom_range(0, 65535)));
		q = '{8'h78};
		send_name(q, 16'($urandom_range(0, 65535)));
	endtask

	// receiver holds off while the sender keeps offering characters
	task automatic test_output_hold();
		char_q_t q;
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait_drained();
		tx_gaps_on = 1'b0;
		rx_hold_req = 300;
		for (int n = 0; n < 3; n++) begin
			q = random_name();
			send_name(q, 16'($urandom_range(0, 65535)));
		end
		tx_gaps_on = 1'b1;
	endtask

	// sender stops until every message byte has come out
	task automatic test_drain_pause();
		char_q_t q;
		for (int n = 0; n < 2; n++) begin
			q = random_name();
			send_name(q, 16'($urandom_range(0, 65535)));
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			wait_drained();
		end
	endtask

	task automatic test_random_names();
		char_q_t q;
		while (chars_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 3) == 0) begin
				tx_gaps_on = 1'b0;
				rx_stalls_on = 1'b0;
			end else begin
				tx_gaps_on = 1'b1;
				rx_stalls_on = 1'b1;
			end
			if ($urandom_range(0, 9) == 0)
				q = noise_name();
			else
				q = random_name();
			send_name(q, 16'($urandom_range(0, 65535)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		mismatches = 0;
		chars_sent = 0;
		tx_gaps_on = 1'b1;
		rx_stalls_on = 1'b1;
		rx_hold_req = 0;
		enc_label_len = 0;
		enc_in_name = 1'b0;
		enc_overflow = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		test_root_and_single();
		test_empty_labels();
		test_char_boundaries();
		test_label_overflow();
		test_output_hold();
		test_drain_pause();
		test_random_names();

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait_drained();
		repeat (50) @(posedge clk);
		if (mismatches == 0 && msg_bytes_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
